// ===== design/rpti_pkg.sv =====
// ---------------------------------------------------------------------------
// rpti_pkg
// Shared widths, register codes, reset values and payload types of the
// radial profile to image block.
// ---------------------------------------------------------------------------
package rpti_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int DIM_W   = 12;
	localparam int ORG_W   = 11;
	localparam int ASP_W   = 16;
	localparam int LEN_W   = 11;
	localparam int COORD_W = 11;
	localparam int IDX_W   = 10;
	localparam int WORD_W  = 32;

	// wide enough for MAX_DIM and PROFILE_DEPTH up to 8192
	localparam int LIM_W = 14;

	localparam int ABS_W  = 11;
	localparam int FRAC_W = 8;
	localparam int DX2_W  = 2 * ABS_W;
	localparam int DY_W   = ABS_W + ASP_W;
	localparam int DY2_W  = 2 * DY_W;
	localparam int SUM_W  = 56;
	localparam int ROOT_W = SUM_W / 2;
	localparam int RAD_W  = ROOT_W + 1 - FRAC_W;

	localparam int WDATA_W = IDX_W + WORD_W;

	// one half in Q20.8, the format of the square root
	localparam int unsigned ROUND_HALF = 1 << (FRAC_W - 1);

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH    = 3'd0,
		REG_IMAGE_HEIGHT   = 3'd1,
		REG_ORIGIN_X       = 3'd2,
		REG_ORIGIN_Y       = 3'd3,
		REG_ASPECT_RATIO   = 3'd4,
		REG_PROFILE_LENGTH = 3'd5
	} cfg_reg_t;

	localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH    = 12'd256;
	localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT   = 12'd256;
	localparam logic [ORG_W-1:0] RST_ORIGIN_X       = 11'd128;
	localparam logic [ORG_W-1:0] RST_ORIGIN_Y       = 11'd128;
	localparam logic [ASP_W-1:0] RST_ASPECT_RATIO   = 16'd256;
	localparam logic [LEN_W-1:0] RST_PROFILE_LENGTH = 11'd0;

	typedef struct packed {
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic [ORG_W-1:0] origin_x;
		logic [ORG_W-1:0] origin_y;
		logic [ASP_W-1:0] aspect_ratio;
		logic [LEN_W-1:0] profile_length;
	} cfg_t;

	// data holds the squared radius for a query, {index, word} for a write
	typedef struct packed {
		logic             is_query;
		logic             coord_ok;
		logic [SUM_W-1:0] data;
	} q_entry_t;

endpackage

// ===== design/rpti_if.sv =====
// ---------------------------------------------------------------------------
// rpti_if
// Request and response channels of the radial profile to image block.
// ---------------------------------------------------------------------------
interface rpti_req_if;
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic [rpti_pkg::IDX_W-1:0]   entry_index;
	logic [rpti_pkg::WORD_W-1:0]  entry_value;
	logic [rpti_pkg::COORD_W-1:0] pixel_x;
	logic [rpti_pkg::COORD_W-1:0] pixel_y;

	modport source(output valid, req_type, entry_index, entry_value, pixel_x, pixel_y,
		input ready);
	modport sink(input valid, req_type, entry_index, entry_value, pixel_x, pixel_y,
		output ready);
endinterface

interface rpti_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [rpti_pkg::WORD_W-1:0] pixel_value;
	logic                        inside_flag;

	modport source(output valid, pixel_value, inside_flag, input ready);
	modport sink(input valid, pixel_value, inside_flag, output ready);
endinterface

// ===== design/rpti_ram.sv =====
// ---------------------------------------------------------------------------
// rpti_ram
// Simple dual-port RAM, one write port and one read port with registered
// read data.
// ---------------------------------------------------------------------------
module rpti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/rpti_front.sv =====
// ---------------------------------------------------------------------------
// rpti_front
// Accepts request words, classifies them, checks the pixel against the
// filled area and forms the squared radius in three stages.
// ---------------------------------------------------------------------------
module rpti_front #(
	parameter int MAX_DIM = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rpti_pkg::cfg_t     cfg,
	rpti_req_if.sink           req,
	output logic               push,
	output rpti_pkg::q_entry_t push_data,
	input  logic               full
);

	typedef struct packed {
		logic                           is_query;
		logic                           coord_ok;
		logic [rpti_pkg::ABS_W-1:0]     adx;
		logic [rpti_pkg::ABS_W-1:0]     ady;
		logic [rpti_pkg::WDATA_W-1:0]   wdata;
	} s1_t;

	typedef struct packed {
		logic                           is_query;
		logic                           coord_ok;
		logic [rpti_pkg::DX2_W-1:0]     dx2;
		logic [rpti_pkg::DY_W-1:0]      dy;
		logic [rpti_pkg::WDATA_W-1:0]   wdata;
	} s2_t;

	typedef struct packed {
		logic                           is_query;
		logic                           coord_ok;
		logic [rpti_pkg::DX2_W-1:0]     dx2;
		logic [rpti_pkg::DY2_W-1:0]     dy2;
		logic [rpti_pkg::WDATA_W-1:0]   wdata;
	} s3_t;

	logic adv;
	logic vld_s1, vld_s2, vld_s3;
	s1_t  st_s1, st_d1;
	s2_t  st_s2, st_d2;
	s3_t  st_s3, st_d3;

	logic [rpti_pkg::LIM_W-1:0]   w_lim, h_lim;
	logic [rpti_pkg::ORG_W:0]     ox2, oy2;
	logic [rpti_pkg::SUM_W-1:0]   sum;

	assign adv       = !vld_s3 || !full;
	assign req.ready = adv;

	// stage 1: offsets and area check
	always_comb begin
		w_lim = (rpti_pkg::LIM_W'(cfg.image_width) < rpti_pkg::LIM_W'(MAX_DIM)) ?
			rpti_pkg::LIM_W'(cfg.image_width) : rpti_pkg::LIM_W'(MAX_DIM);
		h_lim = (rpti_pkg::LIM_W'(cfg.image_height) < rpti_pkg::LIM_W'(MAX_DIM)) ?
			rpti_pkg::LIM_W'(cfg.image_height) : rpti_pkg::LIM_W'(MAX_DIM);
		ox2 = {cfg.origin_x, 1'b0};
		oy2 = {cfg.origin_y, 1'b0};

		st_d1.is_query = (req.req_type == rpti_pkg::REQ_QUERY);
		st_d1.adx = (req.pixel_x >= cfg.origin_x) ? req.pixel_x - cfg.origin_x :
			cfg.origin_x - req.pixel_x;
		st_d1.ady = (req.pixel_y >= cfg.origin_y) ? req.pixel_y - cfg.origin_y :
			cfg.origin_y - req.pixel_y;
		st_d1.coord_ok = ((rpti_pkg::ORG_W+1)'(req.pixel_x) < ox2) &&
			((rpti_pkg::ORG_W+1)'(req.pixel_y) < oy2) &&
			(rpti_pkg::LIM_W'(req.pixel_x) < w_lim) &&
			(rpti_pkg::LIM_W'(req.pixel_y) < h_lim);
		st_d1.wdata = {req.entry_index, req.entry_value};
	end

	// stage 2: dx squared and dy times aspect
	always_comb begin
		st_d2.is_query = st_s1.is_query;
		st_d2.coord_ok = st_s1.coord_ok;
		st_d2.dx2      = rpti_pkg::DX2_W'(st_s1.adx) * rpti_pkg::DX2_W'(st_s1.adx);
		st_d2.dy       = rpti_pkg::DY_W'(st_s1.ady) * rpti_pkg::DY_W'(cfg.aspect_ratio);
		st_d2.wdata    = st_s1.wdata;
	end

	// stage 3: dy squared
	always_comb begin
		st_d3.is_query = st_s2.is_query;
		st_d3.coord_ok = st_s2.coord_ok;
		st_d3.dx2      = st_s2.dx2;
		st_d3.dy2      = rpti_pkg::DY2_W'(st_s2.dy) * rpti_pkg::DY2_W'(st_s2.dy);
		st_d3.wdata    = st_s2.wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1 <= st_d1;
			st_s2 <= st_d2;
			st_s3 <= st_d3;
		end
	end

	// squared radius in Q40.16
	assign sum = (rpti_pkg::SUM_W'(st_s3.dx2) << (2 * rpti_pkg::FRAC_W)) +
		rpti_pkg::SUM_W'(st_s3.dy2);

	assign push               = vld_s3 && !full;
	assign push_data.is_query = st_s3.is_query;
	assign push_data.coord_ok = st_s3.coord_ok;
	assign push_data.data     = st_s3.is_query ? sum : rpti_pkg::SUM_W'(st_s3.wdata);

endmodule

// ===== design/rpti_queue.sv =====
// ---------------------------------------------------------------------------
// rpti_queue
// Small register queue between the front and back parts.
// ---------------------------------------------------------------------------
module rpti_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rpti_pkg::q_entry_t push_data,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output rpti_pkg::q_entry_t head_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	rpti_pkg::q_entry_t ent_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]      cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_data  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/rpti_back.sv =====
// ---------------------------------------------------------------------------
// rpti_back
// Pipelined square root, one root bit per stage, then the profile store
// access and the response register.
// ---------------------------------------------------------------------------
module rpti_back #(
	parameter int PROFILE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rpti_pkg::cfg_t     cfg,
	input  logic               head_valid,
	input  rpti_pkg::q_entry_t head_data,
	output logic               pop,
	rpti_rsp_if.source         rsp
);

	localparam int NSTEP = rpti_pkg::ROOT_W;
	localparam int AW    = $clog2(PROFILE_DEPTH);

	typedef struct packed {
		logic                          is_query;
		logic                          coord_ok;
		logic [rpti_pkg::SUM_W-1:0]    rem;
		logic [rpti_pkg::ROOT_W-1:0]   root;
	} sq_t;

	logic                          adv;
	logic [NSTEP:0]                vld_s;
	sq_t                           sq_s [NSTEP+1];
	sq_t                           last;

	logic [rpti_pkg::ROOT_W:0]     rnd;
	logic [rpti_pkg::RAD_W-1:0]    radius;
	logic [rpti_pkg::LIM_W-1:0]    len_lim;
	logic [rpti_pkg::LIM_W-1:0]    widx;
	logic                          idx_ok;
	logic                          hit;
	logic                          ram_we, ram_re;
	logic [rpti_pkg::WORD_W-1:0]   rdata;
	logic                          rsp_vld_s, hit_s;

	assign adv = !rsp_vld_s || rsp.ready;
	assign pop = adv && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTEP-1:0], head_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0] <= '{is_query: head_data.is_query, coord_ok: head_data.coord_ok,
				rem: head_data.data, root: '0};
		end
	end

	// root bit K: accept when rem >= (root << (K+1)) + 2^(2K)
	for (genvar i = 0; i < NSTEP; i++) begin : g_step
		localparam int K = NSTEP - 1 - i;
		logic [rpti_pkg::SUM_W-1:0] trial;
		sq_t                        nxt;

		always_comb begin
			trial = (rpti_pkg::SUM_W'(sq_s[i].root) << (K + 1)) |
				(rpti_pkg::SUM_W'(1) << (2 * K));
			nxt = sq_s[i];
			if (sq_s[i].is_query && (sq_s[i].rem >= trial)) begin
				nxt.rem  = sq_s[i].rem - trial;
				nxt.root = sq_s[i].root | (rpti_pkg::ROOT_W'(1) << K);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[i+1] <= nxt;
			end
		end
	end

	// round to nearest radius, range checks, store access
	always_comb begin
		last    = sq_s[NSTEP];
		rnd     = (rpti_pkg::ROOT_W+1)'(last.root) + (rpti_pkg::ROOT_W+1)'(rpti_pkg::ROUND_HALF);
		radius  = rpti_pkg::RAD_W'(rnd >> rpti_pkg::FRAC_W);
		len_lim = (rpti_pkg::LIM_W'(cfg.profile_length) < rpti_pkg::LIM_W'(PROFILE_DEPTH)) ?
			rpti_pkg::LIM_W'(cfg.profile_length) : rpti_pkg::LIM_W'(PROFILE_DEPTH);
		hit     = last.is_query && last.coord_ok &&
			(radius < rpti_pkg::RAD_W'(len_lim));
		widx    = rpti_pkg::LIM_W'(last.rem[rpti_pkg::WDATA_W-1:rpti_pkg::WORD_W]);
		idx_ok  = (widx < rpti_pkg::LIM_W'(PROFILE_DEPTH));
		ram_we  = adv && vld_s[NSTEP] && !last.is_query && idx_ok;
		ram_re  = adv && vld_s[NSTEP] && hit;
	end

	rpti_ram #(
		.WIDTH(rpti_pkg::WORD_W),
		.DEPTH(PROFILE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(widx[AW-1:0]),
		.wdata(last.rem[rpti_pkg::WORD_W-1:0]),
		.re   (ram_re),
		.raddr(radius[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_s <= 1'b0;
			hit_s     <= 1'b0;
		end else if (adv) begin
			rsp_vld_s <= vld_s[NSTEP] && last.is_query;
			hit_s     <= hit;
		end
	end

	assign rsp.valid       = rsp_vld_s;
	assign rsp.inside_flag = hit_s;
	assign rsp.pixel_value = hit_s ? rdata : '0;

endmodule

// ===== design/radial_profile_to_image.sv =====
// ---------------------------------------------------------------------------
// radial_profile_to_image
// Maps a stored radial profile of 32-bit words onto a 2-D image.
// req carries words of two kinds: a write stores entry_value at entry_index
// of the profile store and gives no response; a query gives pixel_x and
// pixel_y and gives one rsp word: the profile word at the rounded radius
// from the origin (vertical offset scaled by aspect_ratio), or zero with
// inside_flag clear when the pixel or the radius is out of range.
// Registers are to be written through cfg_we, cfg_index and cfg_data while
// idle, by the user; the block itself does not enforce this. A query passes
// three front stages, the queue, 28 square root stages (one root bit each)
// and the store read. One word is taken every cycle while rsp is taken.
// When rsp stalls, the back part holds and the 4-entry queue fills, then
// req.ready drops. Reset empties all stages and loads register defaults;
// the profile store holds nothing valid until entries are written.
// ---------------------------------------------------------------------------
module radial_profile_to_image #(
	parameter int MAX_DIM       = 2048,
	parameter int PROFILE_DEPTH = 1024,
	parameter int QUEUE_DEPTH   = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rpti_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rpti_pkg::CFG_DATA_W-1:0]   cfg_data,
	rpti_req_if.sink                          req,
	rpti_rsp_if.source                        rsp
);

	rpti_pkg::cfg_t     cfg_q;
	logic               q_push, q_full, q_pop, q_head_valid;
	rpti_pkg::q_entry_t q_push_data, q_head_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width    <= rpti_pkg::RST_IMAGE_WIDTH;
			cfg_q.image_height   <= rpti_pkg::RST_IMAGE_HEIGHT;
			cfg_q.origin_x       <= rpti_pkg::RST_ORIGIN_X;
			cfg_q.origin_y       <= rpti_pkg::RST_ORIGIN_Y;
			cfg_q.aspect_ratio   <= rpti_pkg::RST_ASPECT_RATIO;
			cfg_q.profile_length <= rpti_pkg::RST_PROFILE_LENGTH;
		end else if (cfg_we) begin
			unique case (rpti_pkg::cfg_reg_t'(cfg_index))
				rpti_pkg::REG_IMAGE_WIDTH:
					cfg_q.image_width <= cfg_data[rpti_pkg::DIM_W-1:0];
				rpti_pkg::REG_IMAGE_HEIGHT:
					cfg_q.image_height <= cfg_data[rpti_pkg::DIM_W-1:0];
				rpti_pkg::REG_ORIGIN_X:
					cfg_q.origin_x <= cfg_data[rpti_pkg::ORG_W-1:0];
				rpti_pkg::REG_ORIGIN_Y:
					cfg_q.origin_y <= cfg_data[rpti_pkg::ORG_W-1:0];
				rpti_pkg::REG_ASPECT_RATIO:
					cfg_q.aspect_ratio <= cfg_data[rpti_pkg::ASP_W-1:0];
				rpti_pkg::REG_PROFILE_LENGTH:
					cfg_q.profile_length <= cfg_data[rpti_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	rpti_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.req      (req),
		.push     (q_push),
		.push_data(q_push_data),
		.full     (q_full)
	);

	rpti_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_head_valid),
		.head_data (q_head_data)
	);

	rpti_back #(
		.PROFILE_DEPTH(PROFILE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_valid(q_head_valid),
		.head_data (q_head_data),
		.pop       (q_pop),
		.rsp       (rsp)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue push while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head_valid)
		else $error("queue pop while empty");

	a_outside_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.inside_flag) |-> (rsp.pixel_value == '0))
		else $error("nonzero word with inside flag clear");

	a_full_stalls_req: assert property (@(posedge clk) disable iff (!arst_n)
		(q_full && $past(q_full) && !q_pop) |=> (q_full || q_pop || !q_push))
		else $error("queue state inconsistent after full");

endmodule
